[hw/rtl/kmer_histogram_counter_macros.svh]
// Assertion macros used by the checker file of the k-mer histogram counter.
// No dependencies; included by khc_checker.
`ifndef KMER_HISTOGRAM_COUNTER_MACROS_SVH
`define KMER_HISTOGRAM_COUNTER_MACROS_SVH

// same-cycle implication
`define KHC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KHC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/khc_pkg.sv]
// Shared types and constants of the k-mer histogram counter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package khc_pkg;

    localparam int IDX_W       = 16;   // rolling index, bin address
    localparam int CODE_W      = 5;
    localparam int ALPHA_W     = 6;
    localparam int KLEN_W      = 5;
    localparam int WEIGHT_W    = 16;
    localparam int RUN_W       = 5;
    localparam int OP_W        = 2;
    localparam int OUT_COUNT_W = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 56;

    localparam int DEF_BIN_COUNT   = 65536;
    localparam int DEF_COUNT_WIDTH = 32;

    localparam logic [ALPHA_W-1:0]  ALPHA_RST  = 6'd4;
    localparam logic [KLEN_W-1:0]   KLEN_RST   = 5'd4;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 16'd64;

    // operation codes
    localparam logic [OP_W-1:0] OP_COUNT = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ALPHABET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KMER_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT   = 2'd2;

    typedef struct packed {
        logic rd_en;
        logic count_we;
        logic used_we;
    } khc_mem_ctl_t;

endpackage

[hw/rtl/kmer_histogram_counter.sv]
// K-mer histogram counter: one item at a time, one result beat per item. After reset
// the block sweeps every bin of both stores before s_tready rises; a clear operation
// sweeps the counts and its result follows the sweep. A count beat first waits in
// ST_MODW for the remainder unit (rolling index modulo the leading weight, skipped
// when the weight is zero), then updates the window in ST_MUL. A symbol that completes
// a window and a bin read pass ST_MODB, ST_READ and ST_UPDATE before the result is
// loaded; a symbol that counts nothing and an unknown operation go straight to the
// result. When BIN_COUNT is below 65536 the bin fold adds ST_FOLD to counted symbols
// and reads. s_tready returns in the cycle after the result is loaded; one result may
// wait in the output register while the next item is taken, and a second one holds
// the block until m_tready.
// Depends on khc_pkg, khc_rem_div and khc_bin_mem.
`timescale 1ns / 1ps

module kmer_histogram_counter #(
    parameter int BIN_COUNT   = khc_pkg::DEF_BIN_COUNT,
    parameter int COUNT_WIDTH = khc_pkg::DEF_COUNT_WIDTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // symbol_code[4:0], symbol_bad[5], sequence_start[6], bin_address[22:7], zero[23]
    input  logic [khc_pkg::S_TDATA_W-1:0]    s_tdata,
    // operation[1:0]
    input  logic [khc_pkg::OP_W-1:0]         s_tuser,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // bin_count[31:0], bin_used[32], counted[33], kmer_index[49:34], zero[55:50]
    output logic [khc_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [khc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [khc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import khc_pkg::*;

    localparam int AW = $clog2(BIN_COUNT);
    localparam bit DIRECT_BIN = (BIN_COUNT >= (1 << IDX_W));
    localparam logic [AW-1:0] LAST_BIN = AW'(BIN_COUNT - 1);
    localparam int PAD_W = M_TDATA_W - OUT_COUNT_W - 2 - IDX_W;
    // reciprocal of BIN_COUNT, exact quotient for any index below 2^IDX_W
    localparam int FOLD_SHIFT = IDX_W + AW;
    localparam longint FOLD_RECIP_FULL =
        ((longint'(1) << FOLD_SHIFT) + longint'(BIN_COUNT) - 1) / longint'(BIN_COUNT);
    localparam logic [IDX_W+1:0] FOLD_RECIP   = (IDX_W+2)'(FOLD_RECIP_FULL);
    localparam logic [IDX_W-1:0] FOLD_DIVISOR = IDX_W'(BIN_COUNT);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_MODW, ST_MUL, ST_MODB, ST_FOLD, ST_READ, ST_UPDATE, ST_OUT
    } state_t;

    state_t                 state_reg;
    logic                   clr_used_reg;
    logic [AW-1:0]          clr_addr_reg;
    logic                   m_tvalid_reg;
    logic [M_TDATA_W-1:0]   m_tdata_reg;
    logic [IDX_W-1:0]       rolling_index_reg;
    logic [RUN_W-1:0]       good_run_reg;
    logic [ALPHA_W-1:0]     alpha_reg;
    logic [KLEN_W-1:0]      kmer_len_reg;
    logic [WEIGHT_W-1:0]    weight_reg;

    // per-item payload
    logic [CODE_W-1:0]      code_reg;
    logic                   bad_reg;
    logic                   is_count_reg;
    logic                   weight_zero_reg;
    logic [IDX_W-1:0]       bin_val_reg;
    logic [AW-1:0]          bin_reg;
    logic [2*IDX_W+1:0]     fold_prod_reg;
    logic [OUT_COUNT_W-1:0] res_count_reg;
    logic                   res_used_reg;
    logic                   res_counted_reg;
    logic [IDX_W-1:0]       res_index_reg;

    logic [CODE_W-1:0]      in_code;
    logic                   in_bad;
    logic                   in_start;
    logic [IDX_W-1:0]       in_addr;
    logic                   in_accept;
    logic [IDX_W-1:0]       rolling_eff;

    logic                   div_start;
    logic [IDX_W-1:0]       div_dividend;
    logic [IDX_W-1:0]       div_divisor;
    logic                   div_done;
    logic [IDX_W-1:0]       div_rem;

    logic [IDX_W-1:0]       rest;
    logic [IDX_W+ALPHA_W-1:0] next_sum;
    logic [IDX_W-1:0]       next_index;
    logic [RUN_W-1:0]       good_run_next;
    logic [KLEN_W-1:0]      need;
    logic                   counted_now;

    logic [2*IDX_W+1:0]     fold_prod_next;
    logic [2*IDX_W+1:0]     fold_quo_full;
    logic [IDX_W-1:0]       fold_quo;
    logic [IDX_W-1:0]       fold_rem;
    logic [IDX_W-1:0]       bin_src;
    logic [IDX_W+AW-1:0]    bin_ext;
    logic                   out_load;

    khc_mem_ctl_t           mem_ctl;
    logic [AW-1:0]          mem_addr;
    logic [COUNT_WIDTH-1:0] mem_count_wdata;
    logic                   mem_used_wdata;
    logic [COUNT_WIDTH-1:0] mem_count_rdata;
    logic                   mem_used_rdata;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic [COUNT_WIDTH-1:0] count_result;
    logic [COUNT_WIDTH+OUT_COUNT_W-1:0] count_ext;

    assign in_code   = s_tdata[4:0];
    assign in_bad    = s_tdata[5];
    assign in_start  = s_tdata[6];
    assign in_addr   = s_tdata[22:7];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign rolling_eff = in_start ? '0 : rolling_index_reg;
    assign out_load  = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    // window update
    always_comb begin
        rest          = weight_zero_reg ? '0 : div_rem;
        next_sum      = rest * alpha_reg
                        + (IDX_W+ALPHA_W)'(bad_reg ? '0 : code_reg);
        next_index    = next_sum[IDX_W-1:0];
        good_run_next = bad_reg ? '0
                      : ((good_run_reg == '1) ? good_run_reg : good_run_reg + 1'b1);
        need          = (kmer_len_reg == '0) ? KLEN_W'(1) : kmer_len_reg;
        counted_now   = !bad_reg && (good_run_next >= need);
    end

    // remainder unit reduces the rolling index by the leading weight
    always_comb begin
        div_start    = in_accept && (s_tuser == OP_COUNT) && (weight_reg != '0);
        div_dividend = rolling_eff;
        div_divisor  = weight_reg;
    end

    khc_rem_div #(
        .W(IDX_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .remainder(div_rem)
    );

    // bin fold: product registered in ST_MODB, remainder taken in ST_FOLD
    always_comb begin
        fold_prod_next = bin_val_reg * FOLD_RECIP;
        fold_quo_full  = fold_prod_reg >> FOLD_SHIFT;
        fold_quo       = fold_quo_full[IDX_W-1:0];
        fold_rem       = bin_val_reg - fold_quo * FOLD_DIVISOR;
        bin_src        = DIRECT_BIN ? bin_val_reg : fold_rem;
        bin_ext        = {{AW{1'b0}}, bin_src};
    end

    // bin memory access
    always_comb begin
        mem_ctl.rd_en    = (state_reg == ST_READ);
        mem_ctl.count_we = (state_reg == ST_CLEAR)
                         || (state_reg == ST_UPDATE && is_count_reg);
        mem_ctl.used_we  = (state_reg == ST_CLEAR && clr_used_reg)
                         || (state_reg == ST_UPDATE && is_count_reg);
        mem_addr         = (state_reg == ST_CLEAR) ? clr_addr_reg : bin_reg;
        count_inc        = (mem_count_rdata == '1) ? mem_count_rdata
                                                   : mem_count_rdata + 1'b1;
        count_result     = is_count_reg ? count_inc : mem_count_rdata;
        count_ext        = {{OUT_COUNT_W{1'b0}}, count_result};
        mem_count_wdata  = (state_reg == ST_CLEAR) ? '0 : count_inc;
        mem_used_wdata   = (state_reg != ST_CLEAR);
    end

    khc_bin_mem #(
        .DEPTH (BIN_COUNT),
        .DATA_W(COUNT_WIDTH),
        .AW    (AW)
    ) u_mem (
        .aclk       (aclk),
        .ctl        (mem_ctl),
        .addr       (mem_addr),
        .count_wdata(mem_count_wdata),
        .used_wdata (mem_used_wdata),
        .count_rdata(mem_count_rdata),
        .used_rdata (mem_used_rdata)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_CLEAR;
            clr_used_reg      <= 1'b1;
            clr_addr_reg      <= '0;
            m_tvalid_reg      <= 1'b0;
            rolling_index_reg <= '0;
            good_run_reg      <= '0;
            alpha_reg         <= ALPHA_RST;
            kmer_len_reg      <= KLEN_RST;
            weight_reg        <= WEIGHT_RST;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_ALPHABET: alpha_reg    <= cfg_data[ALPHA_W-1:0];
                    REG_KMER_LEN: kmer_len_reg <= cfg_data[KLEN_W-1:0];
                    REG_WEIGHT:   weight_reg   <= cfg_data[WEIGHT_W-1:0];
                    default: ;
                endcase
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    if (clr_addr_reg == LAST_BIN) begin
                        clr_addr_reg <= '0;
                        clr_used_reg <= 1'b0;
                        state_reg    <= clr_used_reg ? ST_IDLE : ST_OUT;
                    end else begin
                        clr_addr_reg <= clr_addr_reg + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (in_accept) begin
                        unique case (s_tuser)
                            OP_COUNT: begin
                                if (in_start) begin
                                    rolling_index_reg <= '0;
                                    good_run_reg      <= '0;
                                end
                                state_reg <= ST_MODW;
                            end
                            OP_READ:  state_reg <= ST_MODB;
                            OP_CLEAR: state_reg <= ST_CLEAR;
                            default:  state_reg <= ST_OUT;
                        endcase
                    end
                end
                ST_MODW: begin
                    if (weight_zero_reg || div_done) begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    rolling_index_reg <= next_index;
                    good_run_reg      <= good_run_next;
                    state_reg         <= counted_now ? ST_MODB : ST_OUT;
                end
                ST_MODB: begin
                    if (DIRECT_BIN) begin
                        state_reg <= ST_READ;
                    end else begin
                        state_reg <= ST_FOLD;
                    end
                end
                ST_FOLD:   state_reg <= ST_READ;
                ST_READ:   state_reg <= ST_UPDATE;
                ST_UPDATE: state_reg <= ST_OUT;
                ST_OUT: begin
                    if (out_load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            code_reg        <= in_code;
            bad_reg         <= in_bad || ({1'b0, in_code} >= alpha_reg);
            is_count_reg    <= (s_tuser == OP_COUNT);
            weight_zero_reg <= (weight_reg == '0);
            bin_val_reg     <= in_addr;
            res_count_reg   <= '0;
            res_used_reg    <= 1'b0;
            res_counted_reg <= 1'b0;
            res_index_reg   <= '0;
        end
        if (state_reg == ST_MUL) begin
            bin_val_reg <= next_index;
        end
        if (state_reg == ST_MODB) begin
            fold_prod_reg <= fold_prod_next;
        end
        if (state_reg == ST_MODB || state_reg == ST_FOLD) begin
            bin_reg <= bin_ext[AW-1:0];
        end
        if (state_reg == ST_UPDATE) begin
            res_count_reg   <= count_ext[OUT_COUNT_W-1:0];
            res_used_reg    <= is_count_reg || mem_used_rdata;
            res_counted_reg <= is_count_reg;
            res_index_reg   <= bin_val_reg;
        end
        if (out_load) begin
            m_tdata_reg <= {{PAD_W{1'b0}}, res_index_reg, res_counted_reg,
                            res_used_reg, res_count_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[hw/rtl/khc_rem_div.sv]
// Restoring remainder unit, one quotient bit per cycle.
// Depends on khc_pkg.
`timescale 1ns / 1ps

module khc_rem_div #(
    parameter int W = khc_pkg::IDX_W
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] remainder
);
    import khc_pkg::*;

    localparam int CW = $clog2(W);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] step_reg;
    logic [W-1:0]  quo_reg;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  dvs_reg;
    logic [W:0]    shifted;
    logic [W:0]    diff;
    logic [W-1:0]  rem_step;
    logic          last_step;

    always_comb begin
        shifted   = {rem_reg, quo_reg[W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        rem_step  = diff[W] ? shifted[W-1:0] : diff[W-1:0];
        last_step = (step_reg == CW'(W - 1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && last_step) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            step_reg <= '0;
            quo_reg  <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end else if (busy_reg) begin
            step_reg <= step_reg + 1'b1;
            quo_reg  <= {quo_reg[W-2:0], 1'b0};
            rem_reg  <= rem_step;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

[hw/rtl/khc_bin_mem.sv]
// Histogram storage: bin counts and sticky used flags, one port each,
// registered read. Depends on khc_pkg.
`timescale 1ns / 1ps

module khc_bin_mem #(
    parameter int DEPTH  = khc_pkg::DEF_BIN_COUNT,
    parameter int DATA_W = khc_pkg::DEF_COUNT_WIDTH,
    parameter int AW     = $clog2(DEPTH)
) (
    input  logic                  aclk,
    input  khc_pkg::khc_mem_ctl_t ctl,
    input  logic [AW-1:0]         addr,
    input  logic [DATA_W-1:0]     count_wdata,
    input  logic                  used_wdata,
    output logic [DATA_W-1:0]     count_rdata,
    output logic                  used_rdata
);
    import khc_pkg::*;

    logic [DATA_W-1:0] count_mem [DEPTH];
    logic              used_mem  [DEPTH];
    logic [DATA_W-1:0] count_rdata_reg;
    logic              used_rdata_reg;

    always_ff @(posedge aclk) begin
        if (ctl.count_we) begin
            count_mem[addr] <= count_wdata;
        end
        if (ctl.rd_en) begin
            count_rdata_reg <= count_mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.used_we) begin
            used_mem[addr] <= used_wdata;
        end
        if (ctl.rd_en) begin
            used_rdata_reg <= used_mem[addr];
        end
    end

    assign count_rdata = count_rdata_reg;
    assign used_rdata  = used_rdata_reg;

endmodule

[hw/rtl/khc_checker.sv]
// Port-level checks of the k-mer histogram counter, bound to the top level.
// Depends on khc_pkg and kmer_histogram_counter_macros.svh.
`timescale 1ns / 1ps
`include "kmer_histogram_counter_macros.svh"

module khc_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [khc_pkg::M_TDATA_W-1:0]    m_tdata,
    input logic                             m_tvalid,
    input logic                             m_tready
);
    import khc_pkg::*;

    logic [1:0] pend_reg;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;

    // items taken but not yet delivered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_reg + 2'(in_beat) - 2'(out_beat);
        end
    end

    `KHC_ASSERT_NOW(a_pend_max, aclk, aresetn, 1'b1, pend_reg <= 2'd2, "too many items in flight")
    `KHC_ASSERT_NOW(a_no_orphan, aclk, aresetn, m_tvalid, pend_reg != 2'd0, "result beat without item")
    `KHC_ASSERT_NOW(a_counted_used, aclk, aresetn, m_tvalid && m_tdata[33], m_tdata[32], "counted bin not marked used")
    `KHC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result beat changed")

endmodule

bind kmer_histogram_counter khc_checker u_khc_checker (.*);

[dv/kmer_histogram_counter_tb.sv]
// Self-checking bench for kmer_histogram_counter: directed and random symbol, read and clear
// beats over several register settings, checked against a k-mer tally kept in the bench.
// Depends on khc_pkg and the kmer_histogram_counter RTL.
`timescale 1ns / 1ps

module kmer_histogram_counter_tb;
    import khc_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int              PHASES    = 12;
    localparam int              PHASE_LEN = 100;

    typedef struct packed {
        logic [IDX_W-1:0]       kmer_index;
        logic                   counted;
        logic                   bin_used;
        logic [OUT_COUNT_W-1:0] bin_count;
    } kmer_result_t;

    // Tally of k-mer bins plus the queue of results still owed by the block.
    class kmer_tally_board;
        logic [ALPHA_W-1:0]     alpha_size;
        logic [KLEN_W-1:0]      kmer_len;
        logic [WEIGHT_W-1:0]    lead_weight;
        logic [IDX_W-1:0]       window_index;
        logic [RUN_W-1:0]       run_len;
        logic [OUT_COUNT_W-1:0] bin_tally [int unsigned];
        bit                     bin_seen [int unsigned];
        kmer_result_t           owed_results [$];
        logic [IDX_W-1:0]       recent_hits [$];
        int                     errors;

        function new();
            alpha_size   = ALPHA_RST;
            kmer_len     = KLEN_RST;
            lead_weight  = WEIGHT_RST;
            window_index = '0;
            run_len      = '0;
            errors       = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_ALPHABET: alpha_size  = val[ALPHA_W-1:0];
                REG_KMER_LEN: kmer_len    = val[KLEN_W-1:0];
                REG_WEIGHT:   lead_weight = val[WEIGHT_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        function void note_symbol_beat(logic [OP_W-1:0] op, logic [CODE_W-1:0] code,
                                       logic bad, logic start, logic [IDX_W-1:0] addr);
            kmer_result_t           res;
            logic [31:0]            rest;
            logic [31:0]            next;
            int unsigned            need;
            bit                     bad_sym;
            logic [OUT_COUNT_W-1:0] cur;
            res = '0;
            case (op)
                OP_COUNT: begin
                    if (start) begin
                        window_index = '0;
                        run_len      = '0;
                    end
                    bad_sym = bad || ({1'b0, code} >= alpha_size);
                    rest = (lead_weight != 0) ? 32'(window_index % lead_weight) : 32'd0;
                    next = rest * alpha_size + (bad_sym ? 32'd0 : 32'(code));
                    window_index = next[IDX_W-1:0];
                    if (bad_sym)
                        run_len = '0;
                    else if (run_len < 5'd31)
                        run_len++;
                    need = (kmer_len < 1) ? 1 : kmer_len;
                    if (!bad_sym && run_len >= need) begin
                        // 65536 bins: the index is the bin
                        cur = bin_tally.exists(window_index) ? bin_tally[window_index] : '0;
                        if (cur != '1)
                            cur++;
                        bin_tally[window_index] = cur;
                        bin_seen[window_index]  = 1'b1;
                        res.bin_count  = cur;
                        res.bin_used   = 1'b1;
                        res.counted    = 1'b1;
                        res.kmer_index = window_index;
                        recent_hits = {recent_hits, window_index};
                        if (recent_hits.size() > 32)
                            void'(recent_hits.pop_front());
                    end
                end
                OP_READ: begin
                    res.bin_count  = bin_tally.exists(addr) ? bin_tally[addr] : '0;
                    res.bin_used   = bin_seen.exists(addr) ? bin_seen[addr] : 1'b0;
                    res.kmer_index = addr;
                end
                // used flags survive a clear
                OP_CLEAR: bin_tally.delete();
                default: ;
            endcase
            owed_results = {owed_results, res};
        endfunction

        function void check_result_beat(logic [M_TDATA_W-1:0] beat);
            kmer_result_t exp_res;
            kmer_result_t got;
            if (owed_results.size() == 0) begin
                $error("result beat with nothing expected: %h", beat);
                errors++;
                return;
            end
            exp_res = owed_results.pop_front();
            got     = beat[$bits(kmer_result_t)-1:0];
            if (got.bin_count !== exp_res.bin_count) begin
                $error("bin_count: expected %0d, got %0d", exp_res.bin_count, got.bin_count);
                errors++;
            end
            if (got.bin_used !== exp_res.bin_used) begin
                $error("bin_used: expected %0d, got %0d", exp_res.bin_used, got.bin_used);
                errors++;
            end
            if (got.counted !== exp_res.counted) begin
                $error("counted: expected %0d, got %0d", exp_res.counted, got.counted);
                errors++;
            end
            if (got.kmer_index !== exp_res.kmer_index) begin
                $error("kmer_index: expected %0d, got %0d", exp_res.kmer_index, got.kmer_index);
                errors++;
            end
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic [OP_W-1:0]        s_tuser;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    kmer_tally_board board;
    int              send_idle_pct;
    int              recv_idle_pct;

    int unsigned phase_alpha  [PHASES] = '{4, 2, 32, 2, 32, 5, 3, 7, 3, 32, 6, 20};
    int unsigned phase_klen   [PHASES] = '{4, 2, 2, 16, 3, 5, 1, 3, 10, 16, 0, 3};
    int unsigned phase_weight [PHASES] = '{64, 2, 32, 32768, 1024, 625, 0, 1, 19683,
                                           32768, 36, 400};

    kmer_histogram_counter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_result_beat(m_tdata);
    end

    task automatic push_symbol(input logic [OP_W-1:0] op, input logic [CODE_W-1:0] code,
                               input logic bad, input logic start,
                               input logic [IDX_W-1:0] addr);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, addr, start, bad, code};
        do @(posedge aclk); while (!s_tready);
        board.note_symbol_beat(op, code, bad, start, addr);
    endtask

    // hold the sender until the block owes nothing
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        board.set_reg(idx, val);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int unsigned      alpha;
        int unsigned      klen;
        int               run_left;
        int               clears_left;
        int               rand_done;
        int               roll;
        logic             fresh;
        logic [IDX_W-1:0] addr;

        board         = new();
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = OP_COUNT;
        cfg_valid     = 1'b0;
        cfg_index     = REG_ALPHABET;
        cfg_data      = '0;
        send_idle_pct = 37;
        recv_idle_pct = 45;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: reset settings (alphabet 4, k 4, weight 64)
        push_symbol(OP_READ, 5'd0, 1'b0, 1'b1, 16'h0000);
        push_symbol(OP_READ, 5'd31, 1'b1, 1'b0, 16'hFFFF);
        push_symbol(OP_COUNT, 5'd0, 1'b0, 1'b1, 16'h0000);
        push_symbol(OP_COUNT, 5'd1, 1'b0, 1'b0, 16'hFFFF);
        push_symbol(OP_COUNT, 5'd2, 1'b0, 1'b0, 16'h0000);
        push_symbol(OP_COUNT, 5'd3, 1'b0, 1'b0, 16'h0000);
        push_symbol(OP_COUNT, 5'd3, 1'b0, 1'b0, 16'h0000);
        // code outside the alphabet, then a flagged bad symbol
        push_symbol(OP_COUNT, 5'd31, 1'b0, 1'b0, 16'h0000);
        push_symbol(OP_COUNT, 5'd2, 1'b1, 1'b0, 16'h0000);
        repeat (5) push_symbol(OP_COUNT, 5'd3, 1'b0, 1'b0, 16'h5555);
        push_symbol(OP_READ, 5'd0, 1'b0, 1'b0, 16'd255);
        push_symbol(OP_READ, 5'd0, 1'b0, 1'b0, 16'd27);
        push_symbol(OP_CLEAR, 5'd31, 1'b1, 1'b1, 16'hFFFF);
        push_symbol(OP_READ, 5'd0, 1'b0, 1'b0, 16'd255);
        push_symbol(OP_UNUSED, 5'd21, 1'b1, 1'b1, 16'hAAAA);
        push_symbol(OP_COUNT, 5'd1, 1'b0, 1'b0, 16'h0000);
        // restart in mid-run
        push_symbol(OP_COUNT, 5'd2, 1'b0, 1'b1, 16'h0000);
        repeat (3) push_symbol(OP_COUNT, 5'd1, 1'b0, 1'b0, 16'h0000);
        push_symbol(OP_READ, 5'd0, 1'b0, 1'b0, 16'hAAAA);

        clears_left = 4;
        rand_done   = 0;
        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            alpha = phase_alpha[p];
            klen  = phase_klen[p];
            write_reg(REG_ALPHABET, CFG_DATA_W'(alpha));
            write_reg(REG_KMER_LEN, CFG_DATA_W'(klen));
            write_reg(REG_WEIGHT, CFG_DATA_W'(phase_weight[p]));
            run_left = 0;
            fresh    = 1'b1;
            for (int i = 0; i < PHASE_LEN; i++) begin
                if (rand_done < 400) begin
                    send_idle_pct = 37;
                    recv_idle_pct = 45;
                end else if (rand_done < 800) begin
                    send_idle_pct = 45;
                    recv_idle_pct = 37;
                end else begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                roll = $urandom_range(0, 99);
                if (roll < 72) begin
                    // well-formed run of in-alphabet symbols with the odd bad one
                    if (run_left == 0) begin
                        run_left = $urandom_range(1, 3 * klen + 4);
                        fresh    = ($urandom_range(0, 9) < 7);
                    end
                    push_symbol(OP_COUNT, CODE_W'($urandom_range(0, alpha - 1)),
                                ($urandom_range(0, 99) < 4), fresh,
                                IDX_W'($urandom_range(0, 65535)));
                    fresh = 1'b0;
                    run_left--;
                end else if (roll < 90) begin
                    if (board.recent_hits.size() > 0 && $urandom_range(0, 9) < 7)
                        addr = board.recent_hits[$urandom_range(0,
                                                                board.recent_hits.size() - 1)];
                    else
                        addr = IDX_W'($urandom_range(0, 65535));
                    push_symbol(OP_READ, CODE_W'($urandom_range(0, 31)), 1'($urandom),
                                1'($urandom), addr);
                end else if (roll < 92 && clears_left > 0) begin
                    clears_left--;
                    push_symbol(OP_CLEAR, CODE_W'($urandom_range(0, 31)), 1'($urandom),
                                1'($urandom), IDX_W'($urandom_range(0, 65535)));
                end else if (roll < 94) begin
                    push_symbol(OP_UNUSED, CODE_W'($urandom_range(0, 31)), 1'($urandom),
                                1'($urandom), IDX_W'($urandom_range(0, 65535)));
                end else begin
                    push_symbol(OP_COUNT, CODE_W'($urandom_range(0, 31)), 1'($urandom),
                                1'($urandom), IDX_W'($urandom_range(0, 65535)));
                end
                rand_done++;
            end
        end

        drain_results();
        repeat (64) @(posedge aclk);
        if (board.errors == 0 && board.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // reset sweep and a handful of clear sweeps over every bin, plus ~1200 slow items
    initial begin
        #30_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
